@@ rtl/rcvc_pkg.sv @@
`timescale 1ns / 1ps
// rcvc_pkg: shared types, constants and the color class rules of the vote classifier
// no dependencies; used by every module of the block

package rcvc_pkg;

    localparam int NUM_CLASSES = 7;
    localparam int LEVEL_W     = 12;
    localparam int SHARE_W     = 8;
    localparam int CLASS_W     = 3;
    localparam int COUNT_W     = 4;
    localparam int QUO_W       = 7;

    // class codes
    localparam logic [CLASS_W-1:0] CLS_NONE   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_WHITE  = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_YELLOW = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_PURPLE = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_GREEN  = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_BLUE   = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_RED    = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_VOTES      = 3'd0;
    localparam logic [2:0] REG_WHITE_LOW  = 3'd1;
    localparam logic [2:0] REG_NEAR_HIGH  = 3'd2;
    localparam logic [2:0] REG_YELLOW_LOW = 3'd3;
    localparam logic [2:0] REG_GAP_RED    = 3'd4;
    localparam logic [2:0] REG_GAP_GREEN  = 3'd5;

    // reset values of the registers
    localparam logic [COUNT_W-1:0] RST_VOTES      = 4'd6;
    localparam logic [7:0]         RST_WHITE_LOW  = 8'd10;
    localparam logic [7:0]         RST_NEAR_HIGH  = 8'd60;
    localparam logic [7:0]         RST_YELLOW_LOW = 8'd20;
    localparam logic [7:0]         RST_GAP_RED    = 8'd100;
    localparam logic [7:0]         RST_GAP_GREEN  = 8'd50;

    typedef struct packed {
        logic [COUNT_W-1:0] votes_per_decision;
        logic [7:0]         white_low_margin;
        logic [7:0]         near_high_margin;
        logic [7:0]         yellow_low_margin;
        logic [7:0]         yellow_blue_gap_red;
        logic [7:0]         yellow_blue_gap_green;
    } t_cfg;

    // one classified sample handed from front to back
    typedef struct packed {
        logic [CLASS_W-1:0] sample_class;
        logic [SHARE_W-1:0] blue_share;
        logic [SHARE_W-1:0] green_share;
        logic [SHARE_W-1:0] red_share;
    } t_entry;

    // margins are moved to the other side so all sums stay unsigned in 9 bits
    function automatic logic [CLASS_W-1:0] classify(
        input logic [SHARE_W-1:0] r,
        input logic [SHARE_W-1:0] g,
        input logic [SHARE_W-1:0] b,
        input t_cfg               cfg
    );
        logic [SHARE_W:0] r_wl;
        logic [SHARE_W:0] r_yl;
        logic [SHARE_W:0] g_nh;
        logic [SHARE_W:0] b_nh;
        logic [SHARE_W:0] b_gr;
        logic [SHARE_W:0] b_gg;
        logic [SHARE_W:0] r9;
        logic [SHARE_W:0] g9;
        logic             is_white;
        logic             is_yellow;
        logic [CLASS_W-1:0] cls;
        r9   = {1'b0, r};
        g9   = {1'b0, g};
        r_wl = r9 + {1'b0, cfg.white_low_margin};
        r_yl = r9 + {1'b0, cfg.yellow_low_margin};
        g_nh = g9 + {1'b0, cfg.near_high_margin};
        b_nh = {1'b0, b} + {1'b0, cfg.near_high_margin};
        b_gr = {1'b0, b} + {1'b0, cfg.yellow_blue_gap_red};
        b_gg = {1'b0, b} + {1'b0, cfg.yellow_blue_gap_green};
        is_white  = (r_wl > g9) && (r9 < g_nh) && (r_wl > {1'b0, b}) && (r9 < b_nh);
        is_yellow = (r_yl > g9) && (r9 < g_nh) && (b_gr < r9) && (b_gg < g9)
                    && (r > g) && (r > b);
        if (is_white) begin
            cls = CLS_WHITE;
        end else if (is_yellow) begin
            cls = CLS_YELLOW;
        end else if (r > b && b > g) begin
            cls = CLS_PURPLE;
        end else if (g > r && g > b) begin
            cls = CLS_GREEN;
        end else if (b > r && b > g) begin
            cls = CLS_BLUE;
        end else if (r > g && r > b) begin
            cls = CLS_RED;
        end else begin
            cls = CLS_NONE;
        end
        return cls;
    endfunction

endpackage

@@ rtl/rgb_color_vote_classifier_core.sv @@
`timescale 1ns / 1ps
// rgb_color_vote_classifier_core: top level, configuration registers and the
// front / queue / back split; uses rcvc_pkg, rcvc_front, rcvc_queue, rcvc_back
//
// Usage:
// - slave stream takes one sample per transaction: ambient, red, green and blue
//   levels, each signed 12 bits; one result transaction comes out per sample
// - result: three shares scaled to 0..255, the sample class, and on tuser a flag
//   that the sample closed a voting window; decided class is then in tdata
// - configuration: write enable, register index and data; write only while idle
// - the front works on one sample at a time (accept, load, 7 divide steps, two
//   scaling steps, hand-off) and accepts a new sample only after it has handed
//   the current one to the queue; the hand-off waits while the queue is full
// - the back only limits the rate when the receiver stalls the output register
// - reset clears votes, window count and all valid flags and loads the default
//   register values
// - when the receiver stalls, the output register holds, the queue fills, and
//   then o_s_axis_tready stays low while the front waits to hand off its sample

module rgb_color_vote_classifier_core #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // ambient_level, red_level, green_level, blue_level
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // red_share, green_share, blue_share, sample_class, decided_class, zero pad
    output logic [31:0] o_m_axis_tdata,
    // decision_valid
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import rcvc_pkg::*;

    t_cfg   r_cfg;
    t_entry w_push_entry;
    t_entry w_pop_entry;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.votes_per_decision    <= RST_VOTES;
            r_cfg.white_low_margin      <= RST_WHITE_LOW;
            r_cfg.near_high_margin      <= RST_NEAR_HIGH;
            r_cfg.yellow_low_margin     <= RST_YELLOW_LOW;
            r_cfg.yellow_blue_gap_red   <= RST_GAP_RED;
            r_cfg.yellow_blue_gap_green <= RST_GAP_GREEN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_VOTES:      r_cfg.votes_per_decision    <= i_cfg_data[COUNT_W-1:0];
                REG_WHITE_LOW:  r_cfg.white_low_margin      <= i_cfg_data;
                REG_NEAR_HIGH:  r_cfg.near_high_margin      <= i_cfg_data;
                REG_YELLOW_LOW: r_cfg.yellow_low_margin     <= i_cfg_data;
                REG_GAP_RED:    r_cfg.yellow_blue_gap_red   <= i_cfg_data;
                REG_GAP_GREEN:  r_cfg.yellow_blue_gap_green <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rcvc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .o_entry (w_push_entry),
        .i_full  (w_full)
    );

    rcvc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_empty)
    );

    rcvc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_entry (w_pop_entry),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser)
    );

endmodule

@@ rtl/rcvc_front.sv @@
`timescale 1ns / 1ps
// rcvc_front: takes one level set, removes ambient, divides out the three shares
// with a shared-step restoring divider per lane, scales and classifies; uses rcvc_pkg

module rcvc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [47:0]           i_data,
    input  rcvc_pkg::t_cfg        i_cfg,
    output logic                  o_push,
    output rcvc_pkg::t_entry      o_entry,
    input  logic                  i_full
);
    import rcvc_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_LOAD  = 6'b000010,
        F_DIV   = 6'b000100,
        F_MAP   = 6'b001000,
        F_SCALE = 6'b010000,
        F_PUSH  = 6'b100000
    } t_fstate;

    localparam int TOT_W = LEVEL_W + 2;
    localparam int REM_W = TOT_W + QUO_W - 1;

    t_fstate r_state, n_state;

    logic [2:0][LEVEL_W-1:0] r_diff;
    logic [TOT_W-1:0]        r_total;
    logic [REM_W-1:0]        r_dvs;
    logic [2:0][REM_W-1:0]   r_rem;
    logic [2:0][QUO_W-1:0]   r_quo;
    logic [2:0][10:0]        r_x;
    logic [2:0][SHARE_W-1:0] r_share;
    logic [2:0]              r_step;

    logic signed [LEVEL_W:0] w_diff [3];
    logic [TOT_W-1:0]        w_sum;
    logic [QUO_W-1:0]        w_q [3];
    logic [21:0]             w_prod [3];

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = $signed({i_data[LEVEL_W*(k+2)-1], i_data[LEVEL_W*(k+1) +: LEVEL_W]})
                      - $signed({i_data[LEVEL_W-1], i_data[LEVEL_W-1:0]});
            w_q[k]    = (r_total == '0) ? '0 : r_quo[k];
            w_prod[k] = 22'(r_x[k]) * 22'd1639;
        end
        w_sum = TOT_W'(r_diff[0]) + TOT_W'(r_diff[1]) + TOT_W'(r_diff[2]);
    end

    always_comb begin
        o_entry.red_share    = r_share[0];
        o_entry.green_share  = r_share[1];
        o_entry.blue_share   = r_share[2];
        o_entry.sample_class = classify(r_share[0], r_share[1], r_share[2], i_cfg);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_LOAD;
            F_LOAD:  n_state = F_DIV;
            F_DIV:   if (r_step == '0) n_state = F_MAP;
            F_MAP:   n_state = F_SCALE;
            F_SCALE: n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_diff[k] <= w_diff[k][LEVEL_W] ? '0 : w_diff[k][LEVEL_W-1:0];
                end
            end
            F_LOAD: begin
                r_total <= w_sum;
                r_dvs   <= REM_W'(w_sum) << (QUO_W - 1);
                r_step  <= 3'(QUO_W - 1);
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= REM_W'(r_diff[k]) * REM_W'(100);
                    r_quo[k] <= '0;
                end
            end
            F_DIV: begin
                // one restoring step per lane, divisor walks down one bit a cycle
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[k] >= r_dvs) begin
                        r_rem[k] <= r_rem[k] - r_dvs;
                        r_quo[k] <= {r_quo[k][QUO_W-2:0], 1'b1};
                    end else begin
                        r_quo[k] <= {r_quo[k][QUO_W-2:0], 1'b0};
                    end
                end
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 3'd1;
            end
            F_MAP: begin
                // share*255/100 = (share*51/4)/5
                for (int k = 0; k < 3; k++) begin
                    r_x[k] <= 11'((13'(w_q[k]) * 13'd51) >> 2);
                end
            end
            F_SCALE: begin
                // divide by 5 as multiply by ceil(2^13/5), exact below 2730
                for (int k = 0; k < 3; k++) begin
                    r_share[k] <= w_prod[k][20:13];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/rcvc_queue.sv @@
`timescale 1ns / 1ps
// rcvc_queue: small first-in first-out queue of classified samples between front and back
// uses rcvc_pkg for the entry type

module rcvc_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rcvc_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output rcvc_pkg::t_entry o_entry,
    output logic             o_empty
);
    import rcvc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ rtl/rcvc_back.sv @@
`timescale 1ns / 1ps
// rcvc_back: takes classified samples from the queue, counts votes, picks the window
// winner and drives the output register; uses rcvc_pkg

module rcvc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rcvc_pkg::t_cfg   i_cfg,
    input  rcvc_pkg::t_entry i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_data,
    output logic             o_user
);
    import rcvc_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE   = 2'b01,
        B_DECIDE = 2'b10
    } t_bstate;

    t_bstate r_state, n_state;

    logic [COUNT_W-1:0] r_votes [NUM_CLASSES];
    logic [COUNT_W-1:0] r_samples;
    t_entry             r_cur;
    logic               r_valid;
    logic [31:0]        r_data;
    logic               r_user;

    logic [COUNT_W-1:0] w_limit;
    logic               w_done;
    logic [COUNT_W-1:0] w_best;
    logic [CLASS_W-1:0] w_winner;
    logic               w_load;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign w_load  = (r_state == B_DECIDE) && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

    always_comb begin
        w_limit = (i_cfg.votes_per_decision == '0) ? COUNT_W'(1) : i_cfg.votes_per_decision;
        w_done  = (r_samples >= w_limit);
        // first class with the highest count wins ties
        w_best   = r_votes[0];
        w_winner = CLS_NONE;
        for (int i = 1; i < NUM_CLASSES; i++) begin
            if (r_votes[i] > w_best) begin
                w_best   = r_votes[i];
                w_winner = CLASS_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (!i_empty) n_state = B_DECIDE;
            B_DECIDE: if (w_load) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_samples <= '0;
            r_valid   <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_votes[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_samples <= r_samples + COUNT_W'(1);
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    if (i_entry.sample_class == CLASS_W'(i)) begin
                        r_votes[i] <= r_votes[i] + COUNT_W'(1);
                    end
                end
            end
            if (w_load && w_done) begin
                r_samples <= '0;
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    r_votes[i] <= '0;
                end
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
        if (w_load) begin
            r_data <= {2'b00, (w_done ? w_winner : CLS_NONE), r_cur.sample_class,
                       r_cur.blue_share, r_cur.green_share, r_cur.red_share};
            r_user <= w_done;
        end
    end

endmodule
